// File: hw/rtl/windowed_score_class_detector_assert.svh
// Assertion macros for the windowed score class detector.
`ifndef WINDOWED_SCORE_CLASS_DETECTOR_ASSERT_SVH
`define WINDOWED_SCORE_CLASS_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS
`define WSCD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("windowed_score_class_detector: same-cycle check failed");
`define WSCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("windowed_score_class_detector: next-cycle check failed");
`else
`define WSCD_ASSERT_SAME(label, clk, rst, ante, cons)
`define WSCD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hw/rtl/wscd_pkg.sv
// Package with types, constants and helpers of the windowed score class detector.
package wscd_pkg;

   localparam int HISTORY_DEPTH = 16;
   localparam int CATEGORIES = 8;
   localparam int SCORE_BITS = 8;

   localparam int SCORE_SLOT = 8;
   localparam int SCORES_BITS = 64;
   localparam int TIME_BITS = 31;
   localparam int CAT_BITS = 3;
   localparam int AVG_BITS = 8;
   localparam int FRAMES_BITS = 5;
   localparam int WINDOW_BITS = 5;
   localparam int THRESH_BITS = 8;
   localparam int MINF_BITS = 5;
   localparam int EVENT_BITS = 32;

   localparam int PTR_BITS = $clog2(HISTORY_DEPTH);
   localparam int COUNT_BITS = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_BITS = SCORE_BITS + PTR_BITS;
   localparam int CAT_IDX_BITS = $clog2(CATEGORIES);
   localparam int ENTRY_BITS = SCORES_BITS + TIME_BITS;
   localparam int DIV_STEP_BITS = $clog2(SUM_BITS + 1);

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 31;

   localparam int REQ_TDATA_BITS = ((ENTRY_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = CAT_BITS + AVG_BITS + 1 + FRAMES_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS = RSP_TDATA_BITS - RSP_FIELD_BITS;

   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 5'd3;
   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 8'd200;
   localparam logic [TIME_BITS-1:0] SUPPRESS_RESET = 31'd1000;
   localparam logic [MINF_BITS-1:0] MINF_RESET = 5'd1;
   localparam logic [TIME_BITS-1:0] MAX_AGE_RESET = 31'd1000;
   localparam logic [CAT_BITS-1:0] SILENCE_RESET = 3'd0;
   localparam logic signed [EVENT_BITS-1:0] LAST_EVENT_RESET = -32'sd1000000;

   typedef logic [SUM_BITS-1:0] sum_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW_FRAMES,
      CSR_DETECT_THRESHOLD,
      CSR_SUPPRESS_MS,
      CSR_MIN_FRAMES,
      CSR_AGE_LIMIT,
      CSR_SILENCE_CATEGORY
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_ARGMAX,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   function automatic logic [SCORE_BITS-1:0] score_of(input logic [SCORES_BITS-1:0] scores,
                                                      input int k);
      score_of = scores[k*SCORE_SLOT +: SCORE_BITS];
   endfunction

endpackage

// File: hw/rtl/wscd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module wscd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/wscd_div.sv
// Restoring divider that produces one quotient bit per cycle.
module wscd_div
   import wscd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  sum_type               dividend,
   input  logic [COUNT_BITS-1:0] divisor,
   output logic                  done,
   output sum_type               quotient
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_STEP_BITS-1:0] step_ff, step_in;
   logic [COUNT_BITS-1:0]    rem_ff, rem_in;
   sum_type                  quo_ff, quo_in;
   logic [COUNT_BITS-1:0]    divisor_ff, divisor_in;
   logic [COUNT_BITS:0]      trial;
   logic [COUNT_BITS:0]      diff;
   logic                     fits;

   always_comb begin
      trial = {rem_ff, quo_ff[SUM_BITS-1]};
      diff = trial - {1'b0, divisor_ff};
      fits = trial >= {1'b0, divisor_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = DIV_STEP_BITS'(SUM_BITS);
         rem_in = '0;
         quo_in = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
         quo_in = {quo_ff[SUM_BITS-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == DIV_STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hw/rtl/windowed_score_class_detector.sv
// Top level of the windowed score class detector: history ring, walk, argmax and decision.
// After a request is accepted, the walk reads N entries, one per cycle, then the argmax, the
// division and the decision follow before rsp_tvalid; too few entries skip the argmax and division.
// A request is taken in the cycle after its result is loaded, so no new request is taken before
// then, and loading waits while rsp_tready holds the previous result.
// Synchronous reset restores the registers to their defaults and empties the history ring.
`include "windowed_score_class_detector_assert.svh"

module windowed_score_class_detector
   import wscd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // frame_scores [63:0], now_ms [94:64], zero pad [95]
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // category [2:0], avg_score [10:3], new_note [11], frames_used [16:12], zero pad [23:17]
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   state_type state_ff, state_in;

   logic [WINDOW_BITS-1:0] window_ff, window_in;
   logic [THRESH_BITS-1:0] thresh_ff, thresh_in;
   logic [TIME_BITS-1:0]   suppress_ff, suppress_in;
   logic [MINF_BITS-1:0]   minf_ff, minf_in;
   logic [TIME_BITS-1:0]   max_age_ff, max_age_in;
   logic [CAT_BITS-1:0]    silence_ff, silence_in;

   logic [PTR_BITS-1:0]    slot_ff, slot_in;
   logic [COUNT_BITS-1:0]  fill_ff, fill_in;
   logic                   last_valid_ff, last_valid_in;
   logic [CAT_BITS-1:0]    last_cat_ff, last_cat_in;
   logic signed [EVENT_BITS-1:0] last_event_ff, last_event_in;
   logic [CAT_BITS-1:0]    reported_ff, reported_in;

   logic [TIME_BITS-1:0]   now_ff, now_in;
   logic [COUNT_BITS-1:0]  limit_ff, limit_in;
   logic [COUNT_BITS-1:0]  need_ff, need_in;
   logic [PTR_BITS-1:0]    ptr_ff, ptr_in;
   logic [COUNT_BITS-1:0]  issued_ff, issued_in;
   logic                   rv_ff, rv_in;
   logic [COUNT_BITS-1:0]  used_ff, used_in;
   sum_type                sums_ff [CATEGORIES];
   sum_type                sums_in [CATEGORIES];
   logic [CAT_IDX_BITS-1:0] cat_ff, cat_in;
   logic [CAT_BITS-1:0]    best_ff, best_in;
   sum_type                best_sum_ff, best_sum_in;
   logic [CAT_BITS-1:0]    res_cat_ff, res_cat_in;
   logic [AVG_BITS-1:0]    res_avg_ff, res_avg_in;
   logic                   res_note_ff, res_note_in;

   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [CAT_BITS-1:0]    out_cat_ff, out_cat_in;
   logic [AVG_BITS-1:0]    out_avg_ff, out_avg_in;
   logic                   out_note_ff, out_note_in;
   logic [FRAMES_BITS-1:0] out_used_ff, out_used_in;

   logic                   accept;
   logic                   ram_we;
   logic                   div_start;
   logic                   load_out;
   logic                   out_free;
   logic [ENTRY_BITS-1:0]  ram_rdata;
   logic [SCORES_BITS-1:0] rd_scores;
   logic [TIME_BITS-1:0]   rd_time;
   logic                   div_done;
   sum_type                div_quotient;

   logic [COUNT_BITS-1:0]  win;
   logic [COUNT_BITS-1:0]  need;
   logic                   issue;
   logic signed [EVENT_BITS-1:0] age;
   logic                   too_old;
   logic [COUNT_BITS-1:0]  used_plus;
   logic [COUNT_BITS-1:0]  used_final;
   logic                   walk_exit;
   logic                   few;
   logic                   last_cat_step;
   sum_type                candidate;
   logic [AVG_BITS-1:0]    avg;
   logic signed [EVENT_BITS:0] since;
   logic                   suppressed;

   wscd_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (HISTORY_DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot_ff),
      .wr_data (req_tdata[ENTRY_BITS-1:0]),
      .rd_addr (ptr_ff),
      .rd_data (ram_rdata)
   );

   wscd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (best_sum_ff),
      .divisor  (used_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rd_scores = ram_rdata[SCORES_BITS-1:0];
   assign rd_time = ram_rdata[ENTRY_BITS-1:SCORES_BITS];
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      if (window_ff == '0) begin
         win = COUNT_BITS'(1);
      end else if (32'(window_ff) > 32'(HISTORY_DEPTH)) begin
         win = COUNT_BITS'(HISTORY_DEPTH);
      end else begin
         win = COUNT_BITS'(window_ff);
      end
      if (minf_ff == '0) begin
         need = COUNT_BITS'(1);
      end else if (32'(minf_ff) > 32'(win)) begin
         need = win;
      end else begin
         need = COUNT_BITS'(minf_ff);
      end
   end

   always_comb begin
      issue = issued_ff < limit_ff;
      age = $signed({1'b0, now_ff}) - $signed({1'b0, rd_time});
      too_old = age > $signed({1'b0, max_age_ff});
      used_plus = used_ff + 1'b1;
      walk_exit = rv_ff && (too_old || used_plus == limit_ff);
      used_final = too_old ? used_ff : used_plus;
      few = used_final < need_ff;
      last_cat_step = cat_ff == CAT_IDX_BITS'(CATEGORIES - 1);
      candidate = sums_ff[cat_ff];
      avg = AVG_BITS'(div_quotient);
      since = $signed({2'b0, now_ff}) - $signed({last_event_ff[EVENT_BITS-1], last_event_ff});
      suppressed = last_valid_ff && best_ff == last_cat_ff &&
                   since < $signed({2'b0, suppress_ff});
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_exit) begin
               state_in = few ? ST_FINISH : ST_ARGMAX;
            end
         end
         ST_ARGMAX: begin
            if (last_cat_step) begin
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      ram_we = 1'b0;
      div_start = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            ram_we = req_tvalid;
         end
         ST_DIV_START: begin
            div_start = 1'b1;
         end
         ST_FINISH: begin
            load_out = out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      window_in = window_ff;
      thresh_in = thresh_ff;
      suppress_in = suppress_ff;
      minf_in = minf_ff;
      max_age_in = max_age_ff;
      silence_in = silence_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW_FRAMES:    window_in = csr_wdata[WINDOW_BITS-1:0];
            CSR_DETECT_THRESHOLD: thresh_in = csr_wdata[THRESH_BITS-1:0];
            CSR_SUPPRESS_MS:      suppress_in = csr_wdata[TIME_BITS-1:0];
            CSR_MIN_FRAMES:       minf_in = csr_wdata[MINF_BITS-1:0];
            CSR_AGE_LIMIT:        max_age_in = csr_wdata[TIME_BITS-1:0];
            CSR_SILENCE_CATEGORY: silence_in = csr_wdata[CAT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      slot_in = slot_ff;
      fill_in = fill_ff;
      now_in = now_ff;
      limit_in = limit_ff;
      need_in = need_ff;
      ptr_in = ptr_ff;
      issued_in = issued_ff;
      rv_in = 1'b0;
      used_in = used_ff;
      sums_in = sums_ff;
      cat_in = cat_ff;
      best_in = best_ff;
      best_sum_in = best_sum_ff;
      res_cat_in = res_cat_ff;
      res_avg_in = res_avg_ff;
      res_note_in = res_note_ff;
      last_valid_in = last_valid_ff;
      last_cat_in = last_cat_ff;
      last_event_in = last_event_ff;
      reported_in = reported_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               slot_in = (slot_ff == PTR_BITS'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
               fill_in = (fill_ff == COUNT_BITS'(HISTORY_DEPTH)) ? fill_ff : fill_ff + 1'b1;
               limit_in = (fill_in < win) ? fill_in : win;
               need_in = need;
               now_in = req_tdata[ENTRY_BITS-1:SCORES_BITS];
               ptr_in = slot_ff;
               issued_in = '0;
               used_in = '0;
               for (int c = 0; c < CATEGORIES; c++) begin
                  sums_in[c] = '0;
               end
            end
         end
         ST_WALK: begin
            if (issue) begin
               issued_in = issued_ff + 1'b1;
               ptr_in = (ptr_ff == '0) ? PTR_BITS'(HISTORY_DEPTH - 1) : ptr_ff - 1'b1;
               rv_in = 1'b1;
            end
            if (rv_ff && !too_old) begin
               used_in = used_plus;
               for (int c = 0; c < CATEGORIES; c++) begin
                  sums_in[c] = sums_ff[c] + SUM_BITS'(score_of(rd_scores, c));
               end
            end
            if (walk_exit) begin
               best_in = '0;
               best_sum_in = sums_in[0];
               cat_in = CAT_IDX_BITS'(1);
               res_cat_in = reported_ff;
               res_avg_in = '0;
               res_note_in = 1'b0;
            end
         end
         ST_ARGMAX: begin
            if (candidate > best_sum_ff) begin
               best_in = CAT_BITS'(cat_ff);
               best_sum_in = candidate;
            end
            cat_in = cat_ff + 1'b1;
         end
         ST_DECIDE: begin
            res_cat_in = best_ff;
            res_avg_in = avg;
            res_note_in = 1'b0;
            if (avg >= thresh_ff) begin
               if (best_ff == silence_ff) begin
                  last_valid_in = 1'b1;
                  last_cat_in = best_ff;
                  reported_in = best_ff;
               end else if (!suppressed) begin
                  last_valid_in = 1'b1;
                  last_cat_in = best_ff;
                  last_event_in = $signed({1'b0, now_ff});
                  reported_in = best_ff;
                  res_note_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_cat_in = out_cat_ff;
      out_avg_in = out_avg_ff;
      out_note_in = out_note_ff;
      out_used_in = out_used_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (load_out) begin
         rsp_tvalid_in = 1'b1;
         out_cat_in = res_cat_ff;
         out_avg_in = res_avg_ff;
         out_note_in = res_note_ff;
         out_used_in = FRAMES_BITS'(used_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         window_ff <= WINDOW_RESET;
         thresh_ff <= THRESH_RESET;
         suppress_ff <= SUPPRESS_RESET;
         minf_ff <= MINF_RESET;
         max_age_ff <= MAX_AGE_RESET;
         silence_ff <= SILENCE_RESET;
         slot_ff <= '0;
         fill_ff <= '0;
         last_valid_ff <= 1'b0;
         last_cat_ff <= '0;
         last_event_ff <= LAST_EVENT_RESET;
         reported_ff <= SILENCE_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         window_ff <= window_in;
         thresh_ff <= thresh_in;
         suppress_ff <= suppress_in;
         minf_ff <= minf_in;
         max_age_ff <= max_age_in;
         silence_ff <= silence_in;
         slot_ff <= slot_in;
         fill_ff <= fill_in;
         last_valid_ff <= last_valid_in;
         last_cat_ff <= last_cat_in;
         last_event_ff <= last_event_in;
         reported_ff <= reported_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff <= now_in;
      limit_ff <= limit_in;
      need_ff <= need_in;
      ptr_ff <= ptr_in;
      issued_ff <= issued_in;
      rv_ff <= rv_in;
      used_ff <= used_in;
      sums_ff <= sums_in;
      cat_ff <= cat_in;
      best_ff <= best_in;
      best_sum_ff <= best_sum_in;
      res_cat_ff <= res_cat_in;
      res_avg_ff <= res_avg_in;
      res_note_ff <= res_note_in;
      out_cat_ff <= out_cat_in;
      out_avg_ff <= out_avg_in;
      out_note_ff <= out_note_in;
      out_used_ff <= out_used_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = {{RSP_PAD_BITS{1'b0}}, out_used_ff, out_note_ff, out_avg_ff, out_cat_ff};

   `WSCD_ASSERT_NEXT(a_accept_starts_walk, clock, reset, req_tvalid && req_tready, state_ff == ST_WALK)
   `WSCD_ASSERT_SAME(a_used_nonzero, clock, reset, rsp_tvalid_ff, out_used_ff != '0)
   `WSCD_ASSERT_SAME(a_note_is_detection, clock, reset, rsp_tvalid_ff && out_note_ff, (out_cat_ff != silence_ff) && (out_avg_ff >= thresh_ff))
   `WSCD_ASSERT_SAME(a_div_done_in_wait, clock, reset, div_done, state_ff == ST_DIV_WAIT)

endmodule

// File: tb/sv/detection_checker.sv
// Checker of the windowed score class detector: tracks the history, predicts each result and compares.
`timescale 1ns / 1ps

module detection_checker
   import wscd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        mismatch_count,
   output int                        detections_due
);

   localparam int AVG_LSB = CAT_BITS;
   localparam int NOTE_BIT = CAT_BITS + AVG_BITS;
   localparam int USED_LSB = NOTE_BIT + 1;

   typedef struct packed {
      logic [CAT_BITS-1:0]    category;
      logic [AVG_BITS-1:0]    avg_score;
      logic                   new_note;
      logic [FRAMES_BITS-1:0] frames_used;
   } detection_type;

   logic [WINDOW_BITS-1:0] window_frames;
   logic [THRESH_BITS-1:0] detect_threshold;
   logic [TIME_BITS-1:0]   suppress_ms;
   logic [MINF_BITS-1:0]   min_frames;
   logic [TIME_BITS-1:0]   age_limit;
   logic [CAT_BITS-1:0]    silence_category;

   logic [SCORES_BITS-1:0] ring_scores [HISTORY_DEPTH];
   logic [TIME_BITS-1:0]   ring_times [HISTORY_DEPTH];
   int                     next_slot;
   int                     ring_fill;
   bit                     have_last;
   logic [CAT_BITS-1:0]    last_cat;
   longint                 last_note_ms;
   logic [CAT_BITS-1:0]    shown_cat;

   detection_type          pending_detections [$];
   detection_type          oldest;

   initial begin
      mismatch_count = 0;
      detections_due = 0;
   end

   // Stores the frame in the ring, averages the newest entries and updates the announcement state.
   function automatic detection_type classify_frame(input logic [SCORES_BITS-1:0] scores,
                                                    input logic [TIME_BITS-1:0] now_ms);
      detection_type d;
      int            win;
      int            need;
      int            used;
      int            idx;
      int            best;
      int            avg;
      int            sums [CATEGORIES];
      longint        age;
      ring_scores[next_slot] = scores;
      ring_times[next_slot] = now_ms;
      next_slot = (next_slot + 1) % HISTORY_DEPTH;
      if (ring_fill < HISTORY_DEPTH) ring_fill++;

      win = int'(window_frames);
      if (win < 1) win = 1;
      if (win > HISTORY_DEPTH) win = HISTORY_DEPTH;
      need = int'(min_frames);
      if (need < 1) need = 1;
      if (need > win) need = win;

      for (int c = 0; c < CATEGORIES; c++) sums[c] = 0;
      used = 0;
      for (int back = 0; back < ring_fill && used < win; back++) begin
         idx = (next_slot + 2 * HISTORY_DEPTH - 1 - back) % HISTORY_DEPTH;
         age = longint'(now_ms) - longint'(ring_times[idx]);
         if (age > longint'(age_limit)) break;
         for (int c = 0; c < CATEGORIES; c++)
            sums[c] += int'(ring_scores[idx][c*SCORE_SLOT +: SCORE_BITS]);
         used++;
      end

      d.frames_used = FRAMES_BITS'(used);
      d.new_note = 1'b0;
      if (used < need || used == 0) begin
         d.category = shown_cat;
         d.avg_score = '0;
         return d;
      end

      best = 0;
      for (int c = 1; c < CATEGORIES; c++)
         if (sums[c] > sums[best]) best = c;
      avg = sums[best] / used;
      d.category = CAT_BITS'(best);
      d.avg_score = AVG_BITS'(avg);

      if (avg < int'(detect_threshold)) return d;

      if (CAT_BITS'(best) == silence_category) begin
         have_last = 1'b1;
         last_cat = CAT_BITS'(best);
         shown_cat = CAT_BITS'(best);
         return d;
      end

      if (have_last && CAT_BITS'(best) == last_cat &&
          longint'(now_ms) - last_note_ms < longint'(suppress_ms))
         return d;

      have_last = 1'b1;
      last_cat = CAT_BITS'(best);
      last_note_ms = longint'(now_ms);
      shown_cat = CAT_BITS'(best);
      d.new_note = 1'b1;
      return d;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         window_frames = WINDOW_RESET;
         detect_threshold = THRESH_RESET;
         suppress_ms = SUPPRESS_RESET;
         min_frames = MINF_RESET;
         age_limit = MAX_AGE_RESET;
         silence_category = SILENCE_RESET;
         next_slot = 0;
         ring_fill = 0;
         have_last = 1'b0;
         last_cat = '0;
         last_note_ms = longint'(LAST_EVENT_RESET);
         shown_cat = SILENCE_RESET;
         pending_detections.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_WINDOW_FRAMES: begin
                  window_frames = csr_wdata[WINDOW_BITS-1:0];
               end
               CSR_DETECT_THRESHOLD: begin
                  detect_threshold = csr_wdata[THRESH_BITS-1:0];
               end
               CSR_SUPPRESS_MS: begin
                  suppress_ms = csr_wdata[TIME_BITS-1:0];
               end
               CSR_MIN_FRAMES: begin
                  min_frames = csr_wdata[MINF_BITS-1:0];
               end
               CSR_AGE_LIMIT: begin
                  age_limit = csr_wdata[TIME_BITS-1:0];
               end
               CSR_SILENCE_CATEGORY: begin
                  silence_category = csr_wdata[CAT_BITS-1:0];
               end
               default: begin
               end
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            if (pending_detections.size() == 0) begin
               $display("%0t: result expected none, actual %h", $time, rsp_tdata);
               mismatch_count++;
            end else begin
               oldest = pending_detections.pop_front();
               check_field("category", int'(oldest.category),
                           int'(rsp_tdata[CAT_BITS-1:0]));
               check_field("avg_score", int'(oldest.avg_score),
                           int'(rsp_tdata[AVG_LSB +: AVG_BITS]));
               check_field("new_note", int'(oldest.new_note), int'(rsp_tdata[NOTE_BIT]));
               check_field("frames_used", int'(oldest.frames_used),
                           int'(rsp_tdata[USED_LSB +: FRAMES_BITS]));
            end
         end

         if (req_tvalid && req_tready)
            pending_detections.push_back(classify_frame(req_tdata[SCORES_BITS-1:0],
                                         req_tdata[SCORES_BITS +: TIME_BITS]));
      end
      detections_due = pending_detections.size();
   end

endmodule

// File: tb/sv/tb.sv
// Top of the detector testbench: clock, reset, frame and register stimulus, result sink and verdict.
`timescale 1ns / 1ps

module tb;
   import wscd_pkg::*;

   localparam int MAX_MS = 32'h7FFF_FFFF;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      csr_we = 1'b0;
   csr_index_type             csr_index = CSR_WINDOW_FRAMES;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   int                        mismatch_count;
   int                        detections_due;
   int                        idle_pct = 25;
   bit                        hold_request = 1'b0;
   bit                        hold_taken = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   windowed_score_class_detector DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   detection_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .detections_due (detections_due)
   );

   function automatic logic [SCORES_BITS-1:0] peak_frame(input int cat, input int peak,
                                                         input int base, input bit noisy);
      logic [SCORES_BITS-1:0] s;
      for (int k = 0; k < CATEGORIES; k++)
         s[k*SCORE_SLOT +: SCORE_SLOT] = (k == cat) ? SCORE_SLOT'(peak) :
            (noisy ? SCORE_SLOT'($urandom_range(0, base)) : SCORE_SLOT'(base));
      return s;
   endfunction

   // Offers one request and returns at the edge that accepts it, sometimes followed by a gap.
   task automatic send_frame(input logic [SCORES_BITS-1:0] scores,
                             input logic [TIME_BITS-1:0] now_ms);
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_TDATA_BITS - SCORES_BITS - TIME_BITS){1'b0}}, now_ms, scores};
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (detections_due != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic configure(input int win, input int thr, input int sup, input int minf,
                            input int age, input int sil);
      drain();
      write_reg(CSR_WINDOW_FRAMES, CSR_DATA_BITS'(win));
      write_reg(CSR_DETECT_THRESHOLD, CSR_DATA_BITS'(thr));
      write_reg(CSR_SUPPRESS_MS, CSR_DATA_BITS'(sup));
      write_reg(CSR_MIN_FRAMES, CSR_DATA_BITS'(minf));
      write_reg(CSR_AGE_LIMIT, CSR_DATA_BITS'(age));
      write_reg(CSR_SILENCE_CATEGORY, CSR_DATA_BITS'(sil));
      csr_we <= 1'b0;
   endtask

   initial begin : result_sink
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= idle_pct);
         end
      end
   end

   initial begin : stimulus
      logic [SCORES_BITS-1:0] scores;
      logic [TIME_BITS-1:0]   stamp_ms;
      int                     dom_cat;
      int                     run_left;
      int                     pick;
      int                     tie_cat;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Register defaults: three-frame windows, silence, suppression edges, ties, time extremes.
      send_frame('0, 31'd0);
      send_frame('1, 31'd2000);
      send_frame(peak_frame(5, 250, 10, 1'b0), 31'd4000);
      send_frame(peak_frame(5, 250, 10, 1'b0), 31'd4500);
      send_frame(peak_frame(5, 250, 10, 1'b0), 31'd5000);
      scores = peak_frame(2, 240, 0, 1'b0);
      scores[6*SCORE_SLOT +: SCORE_SLOT] = 8'd240;
      send_frame(scores, 31'd8000);
      send_frame(peak_frame(4, 220, 0, 1'b0), 31'd7000);
      send_frame(peak_frame(7, 255, 0, 1'b0), TIME_BITS'(MAX_MS));
      send_frame(64'hAAAA_AAAA_AAAA_AAAA, TIME_BITS'(MAX_MS));
      send_frame(64'h5555_5555_5555_5555, 31'd0);

      // Too few entries until the window is filled.
      configure(3, 200, 1000, 3, 1000, 0);
      send_frame(peak_frame(1, 255, 0, 1'b0), 31'd100000);
      send_frame(peak_frame(1, 255, 0, 1'b0), 31'd100010);
      send_frame(peak_frame(1, 255, 0, 1'b0), 31'd100020);

      // Zero registers: window and minimum clamp up, no threshold, no suppression, no age.
      configure(0, 0, 0, 0, 0, 7);
      send_frame('0, 31'd200000);
      send_frame('0, 31'd200000);
      send_frame(peak_frame(7, 9, 0, 1'b0), 31'd200001);
      send_frame(peak_frame(7, 9, 3, 1'b0), 31'd200001);

      stamp_ms = 31'd300000;
      dom_cat = 0;
      run_left = 0;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: configure(3, 180, 1000, 1, 1000, 0);
            1: configure(1, 0, 0, 1, 0, 0);
            2: configure(31, 255, MAX_MS, 31, MAX_MS, 7);
            default: begin
               configure(($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) :
                            $urandom_range(0, 31),
                         $urandom_range(100, 230), $urandom_range(0, 3000),
                         $urandom_range(0, 6), $urandom_range(50, 3000),
                         $urandom_range(0, 7));
            end
         endcase
         idle_pct = (phase == 4) ? 0 : 25;
         if (phase == 3) hold_request = 1'b1;

         for (int i = 0; i < 210; i++) begin
            if (run_left == 0) begin
               dom_cat = $urandom_range(0, CATEGORIES - 1);
               run_left = $urandom_range(3, 15);
            end
            run_left--;

            if ($urandom_range(0, 99) < 80) begin
               scores = peak_frame(dom_cat, $urandom_range(150, 255), 120, 1'b1);
               if ($urandom_range(0, 19) == 0) begin
                  tie_cat = (dom_cat + $urandom_range(1, CATEGORIES - 1)) % CATEGORIES;
                  scores[tie_cat*SCORE_SLOT +: SCORE_SLOT] =
                     scores[dom_cat*SCORE_SLOT +: SCORE_SLOT];
               end
            end else begin
               scores = {$urandom, $urandom};
            end

            pick = $urandom_range(0, 99);
            if (pick < 70)
               stamp_ms = stamp_ms + TIME_BITS'($urandom_range(0, 80));
            else if (pick < 85)
               stamp_ms = stamp_ms + TIME_BITS'($urandom_range(300, 2500));
            else if (pick < 92)
               stamp_ms = stamp_ms + TIME_BITS'($urandom_range(0, 200000));
            else if (pick < 97)
               stamp_ms = stamp_ms - TIME_BITS'($urandom_range(1, 600));
            else
               stamp_ms = TIME_BITS'($urandom);

            send_frame(scores, stamp_ms);
         end
      end

      req_tvalid <= 1'b0;
      for (int n = 0; n < 5000 && detections_due != 0; n++) @(negedge clock);
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && detections_due == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #20000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
